// ----- rtl/aabb_pkg.sv -----
// ----------------------------------------------------------------------------
// AABB collision step package
// Shared types, constants and arithmetic helpers for the box collision step.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int MaxBoxes = 64;
	localparam int IdxW     = $clog2(MaxBoxes);
	localparam int CntW     = $clog2(MaxBoxes + 1);

	localparam logic [16:0] TimeStepReset = 17'd1092;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_STEP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Multiplier operand selection.
	typedef enum logic [1:0] {
		MUL_GRAV = 2'd0,
		MUL_VX   = 2'd1,
		MUL_VZ   = 2'd2,
		MUL_VY   = 2'd3
	} mul_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic            load;     // capture the input transaction
		logic            clear;    // empty the box table
		logic            add;      // store the captured box
		logic            mul;      // register one product
		mul_sel_t        msel;
		logic            grav;     // apply the product to velocity y
		logic            move;     // apply the product to the position of axis
		logic [1:0]      axis;     // 0 x, 1 y, 2 z
		logic            rd;       // read table entry idx
		logic [IdxW-1:0] idx;
		logic            chk;      // check the registered entry
		logic            done;     // present the result
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [CntW-1:0] count;
	} dp_sts_t;

	// Saturate a 34-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = 34'sh0_7FFF_FFFF;
		lo = -34'sh0_8000_0000;
		if (x > hi) return 32'sh7FFF_FFFF;
		if (x < lo) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// Product back to Q16.16: add half, floor shift by 16.
	function automatic logic signed [33:0] round_q16(input logic signed [49:0] p);
		logic signed [49:0] q;
		q = p + 50'sd32768;
		return q[49:16];
	endfunction

endpackage

// ----- rtl/aabb_gravity_collision_step.sv -----
// ----------------------------------------------------------------------------
// AABB gravity collision step
// Static box table and one-body gravity step with per-axis box resolution.
// ----------------------------------------------------------------------------
// Channel   Signals                        Direction  Handshake
// command   start, operation, fields       in         start && !busy
// result    new_*, grounded                out        result_valid strobe
// config    time_step_data                 in         time_step_valid && ready
//
// Clear and add complete in the decode state. A step checks the N stored boxes
// one at a time through the box table read port, on each of the three axis
// passes. Reset empties the table and sets time_step to 1092. The result
// strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module aabb_gravity_collision_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic signed [31:0]  position_x,
	input  logic signed [31:0]  position_y,
	input  logic signed [31:0]  position_z,
	input  logic [30:0]         half_size_x,
	input  logic [30:0]         half_size_y,
	input  logic [30:0]         half_size_z,
	input  logic signed [31:0]  velocity_x,
	input  logic signed [31:0]  velocity_y,
	input  logic signed [31:0]  velocity_z,
	input  logic signed [31:0]  gravity,
	input  logic                time_step_valid,
	output logic                time_step_ready,
	input  logic [16:0]         time_step_data,
	output logic                result_valid,
	output logic signed [31:0]  new_position_x,
	output logic signed [31:0]  new_position_y,
	output logic signed [31:0]  new_position_z,
	output logic signed [31:0]  new_velocity_x,
	output logic signed [31:0]  new_velocity_y,
	output logic signed [31:0]  new_velocity_z,
	output logic                grounded
);
	import aabb_pkg::*;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [16:0] time_step_q;

	// Time step register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TimeStepReset;
		end else if (time_step_valid) begin
			time_step_q <= time_step_data;
		end
	end
	assign time_step_ready = 1'b1;

	aabb_ctrl u_ctrl (
		.clk, .arst_n, .start, .operation, .sts, .cmd, .busy
	);

	aabb_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .time_step(time_step_q),
		.position_x, .position_y, .position_z,
		.half_size_x, .half_size_y, .half_size_z,
		.velocity_x, .velocity_y, .velocity_z, .gravity,
		.new_position_x, .new_position_y, .new_position_z,
		.new_velocity_x, .new_velocity_y, .new_velocity_z,
		.grounded, .result_valid
	);

`ifndef SYNTHESIS
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$past(cmd.load))
		else $error("result strobe directly after a command");
	a_res_one: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		sts.count <= CntW'(MaxBoxes))
		else $error("box count beyond capacity");
`endif

endmodule

// ----- rtl/aabb_datapath.sv -----
// ----------------------------------------------------------------------------
// AABB collision datapath
// Box table memory, one shared multiplier and the per-box clamp logic.
// ----------------------------------------------------------------------------
module aabb_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aabb_pkg::dp_cmd_t     cmd,
	output aabb_pkg::dp_sts_t     sts,
	input  logic [16:0]           time_step,
	input  logic signed [31:0]    position_x,
	input  logic signed [31:0]    position_y,
	input  logic signed [31:0]    position_z,
	input  logic [30:0]           half_size_x,
	input  logic [30:0]           half_size_y,
	input  logic [30:0]           half_size_z,
	input  logic signed [31:0]    velocity_x,
	input  logic signed [31:0]    velocity_y,
	input  logic signed [31:0]    velocity_z,
	input  logic signed [31:0]    gravity,
	output logic signed [31:0]    new_position_x,
	output logic signed [31:0]    new_position_y,
	output logic signed [31:0]    new_position_z,
	output logic signed [31:0]    new_velocity_x,
	output logic signed [31:0]    new_velocity_y,
	output logic signed [31:0]    new_velocity_z,
	output logic                  grounded,
	output logic                  result_valid
);
	import aabb_pkg::*;

	// Box table: one row holds both corners of all three axes.
	logic [191:0] mem [MaxBoxes];
	logic [191:0] row_q;
	logic [CntW-1:0] count_q;

	logic signed [31:0] pos_q [3];
	logic [30:0]        half_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] grav_q;
	logic signed [49:0] prod_q;
	logic               gnd_q;
	logic               res_q;

	logic signed [31:0] bmin [3];
	logic signed [31:0] bmax [3];
	logic               hit;
	logic signed [31:0] mul_a;
	logic [1:0]         ax;

	assign ax = cmd.axis;

	// Unpack the registered row.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			bmin[a] = row_q[a*32 +: 32];
			bmax[a] = row_q[96 + a*32 +: 32];
		end
	end

	// Inclusive overlap on all three axes.
	always_comb begin
		hit = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (34'(pos_q[a]) + 34'(signed'({1'b0, half_q[a]})) < 34'(bmin[a]))
				hit = 1'b0;
			if (34'(pos_q[a]) - 34'(signed'({1'b0, half_q[a]})) > 34'(bmax[a]))
				hit = 1'b0;
		end
	end

	always_comb begin
		case (cmd.msel)
			MUL_GRAV: mul_a = grav_q;
			MUL_VX:   mul_a = vel_q[0];
			MUL_VZ:   mul_a = vel_q[2];
			MUL_VY:   mul_a = vel_q[1];
			default:  mul_a = grav_q;
		endcase
	end

	// Box table write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.add && count_q < CntW'(MaxBoxes)) begin
			mem[count_q[IdxW-1:0]] <= {
				sat32(34'(pos_q[2]) + 34'(signed'({1'b0, half_q[2]}))),
				sat32(34'(pos_q[1]) + 34'(signed'({1'b0, half_q[1]}))),
				sat32(34'(pos_q[0]) + 34'(signed'({1'b0, half_q[0]}))),
				sat32(34'(pos_q[2]) - 34'(signed'({1'b0, half_q[2]}))),
				sat32(34'(pos_q[1]) - 34'(signed'({1'b0, half_q[1]}))),
				sat32(34'(pos_q[0]) - 34'(signed'({1'b0, half_q[0]})))};
		end
		if (cmd.rd) begin
			row_q <= mem[cmd.idx];
		end
	end

	// Box count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			res_q   <= 1'b0;
		end else begin
			res_q <= cmd.done;
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.add && count_q < CntW'(MaxBoxes)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Body registers, product register and clamp updates.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q[0]  <= position_x;
			pos_q[1]  <= position_y;
			pos_q[2]  <= position_z;
			half_q[0] <= half_size_x;
			half_q[1] <= half_size_y;
			half_q[2] <= half_size_z;
			vel_q[0]  <= velocity_x;
			vel_q[1]  <= velocity_y;
			vel_q[2]  <= velocity_z;
			grav_q    <= gravity;
			gnd_q     <= 1'b0;
		end
		if (cmd.mul) begin
			prod_q <= 50'(mul_a) * 50'(signed'({1'b0, time_step}));
		end
		if (cmd.grav) begin
			vel_q[1] <= sat32(34'(vel_q[1]) - round_q16(prod_q));
		end
		if (cmd.move) begin
			pos_q[ax] <= sat32(34'(pos_q[ax]) + round_q16(prod_q));
		end
		if (cmd.chk && hit) begin
			if (vel_q[ax] > 0) begin
				pos_q[ax] <= sat32(34'(bmin[ax]) - 34'(signed'({1'b0, half_q[ax]})));
			end else if (vel_q[ax] < 0) begin
				pos_q[ax] <= sat32(34'(bmax[ax]) + 34'(signed'({1'b0, half_q[ax]})));
				if (ax == 2'd1) gnd_q <= 1'b1;
			end
			vel_q[ax] <= '0;
		end
	end

	assign sts.count      = count_q;
	assign new_position_x = pos_q[0];
	assign new_position_y = pos_q[1];
	assign new_position_z = pos_q[2];
	assign new_velocity_x = vel_q[0];
	assign new_velocity_y = vel_q[1];
	assign new_velocity_z = vel_q[2];
	assign grounded       = gnd_q;
	assign result_valid   = res_q;

endmodule

// ----- rtl/aabb_ctrl.sv -----
// ----------------------------------------------------------------------------
// AABB collision controller
// Sequences clear, add and the three axis passes of a step.
// ----------------------------------------------------------------------------
module aabb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        operation,
	input  aabb_pkg::dp_sts_t sts,
	output aabb_pkg::dp_cmd_t cmd,
	output logic              busy
);
	import aabb_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DEC   = 9'b000000010,
		S_GMUL  = 9'b000000100,
		S_GAPP  = 9'b000001000,
		S_MUL   = 9'b000010000,
		S_MOVE  = 9'b000100000,
		S_READ  = 9'b001000000,
		S_CHK   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t          state_q;
	logic [1:0]      op_q;
	logic [1:0]      pass_q;  // 0 x, 1 z, 2 y
	logic [CntW-1:0] idx_q;
	logic [1:0]      axis;

	always_comb begin
		case (pass_q)
			2'd0:    axis = 2'd0;
			2'd1:    axis = 2'd2;
			default: axis = 2'd1;
		endcase
	end

	// Command decode.
	always_comb begin
		cmd       = '0;
		cmd.axis  = axis;
		cmd.idx   = idx_q[IdxW-1:0];
		cmd.load  = (state_q == S_IDLE) && start;
		case (state_q)
			S_DEC: begin
				cmd.clear = (op_q == OP_CLEAR);
				cmd.add   = (op_q == OP_ADD);
			end
			S_GMUL: begin
				cmd.mul  = 1'b1;
				cmd.msel = MUL_GRAV;
			end
			S_GAPP: cmd.grav = 1'b1;
			S_MUL: begin
				cmd.mul = 1'b1;
				case (pass_q)
					2'd0:    cmd.msel = MUL_VX;
					2'd1:    cmd.msel = MUL_VZ;
					default: cmd.msel = MUL_VY;
				endcase
			end
			S_MOVE: cmd.move = 1'b1;
			S_READ: cmd.rd   = (idx_q < sts.count);
			S_CHK:  cmd.chk  = 1'b1;
			S_DONE: cmd.done = 1'b1;
			default: ;
		endcase
	end

	// State sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			pass_q  <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					op_q    <= operation;
					state_q <= S_DEC;
				end
				S_DEC: state_q <= (op_q == OP_STEP) ? S_GMUL : S_IDLE;
				S_GMUL: state_q <= S_GAPP;
				S_GAPP: begin
					pass_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_MOVE;
				S_MOVE: begin
					idx_q   <= '0;
					state_q <= S_READ;
				end
				S_READ: begin
					if (idx_q < sts.count) begin
						state_q <= S_CHK;
					end else if (pass_q == 2'd2) begin
						state_q <= S_DONE;
					end else begin
						pass_q  <= pass_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_CHK: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_READ;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- verif/aabb_step_checker.sv -----
// ----------------------------------------------------------------------------
// AABB collision step checker
// Watches the command, config and result channels, predicts each body step
// from its own copy of the box table and time step, and compares results.
// ----------------------------------------------------------------------------
module aabb_step_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         operation,
	input  logic signed [31:0] position_x,
	input  logic signed [31:0] position_y,
	input  logic signed [31:0] position_z,
	input  logic [30:0]        half_size_x,
	input  logic [30:0]        half_size_y,
	input  logic [30:0]        half_size_z,
	input  logic signed [31:0] velocity_x,
	input  logic signed [31:0] velocity_y,
	input  logic signed [31:0] velocity_z,
	input  logic signed [31:0] gravity,
	input  logic               time_step_valid,
	input  logic               time_step_ready,
	input  logic [16:0]        time_step_data,
	input  logic               result_valid,
	input  logic signed [31:0] new_position_x,
	input  logic signed [31:0] new_position_y,
	input  logic signed [31:0] new_position_z,
	input  logic signed [31:0] new_velocity_x,
	input  logic signed [31:0] new_velocity_y,
	input  logic signed [31:0] new_velocity_z,
	input  logic               grounded,
	output int                 fail_count,
	output int                 pending,
	output int                 steps_seen,
	output int                 grounded_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import aabb_pkg::*;

	typedef struct {
		logic signed [31:0] pos [3];
		logic signed [31:0] vel [3];
		logic               gnd;
	} body_state_t;

	body_state_t expected_bodies [$];

	logic signed [31:0] lo_corner [MaxBoxes][3];
	logic signed [31:0] hi_corner [MaxBoxes][3];
	int                 stored_boxes;
	logic [16:0]        step_dt;

	// Clamp a wide signed value into 32 bits.
	function automatic longint clip32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Scale a Q16.16 product back, rounding half toward plus infinity.
	function automatic longint scale_dt(input longint v, input longint dt);
		return (v * dt + 64'sd32768) >>> 16;
	endfunction

	// Pushes the body out of every stored box it touches along one axis.
	function automatic void push_out(inout longint p [3], input longint h [3],
			inout longint v [3], input int ax, inout logic gnd);
		bit hit;
		for (int i = 0; i < stored_boxes; i++) begin
			hit = 1;
			for (int a = 0; a < 3; a++) begin
				if (p[a] + h[a] < longint'(lo_corner[i][a])) hit = 0;
				if (p[a] - h[a] > longint'(hi_corner[i][a])) hit = 0;
			end
			if (!hit) continue;
			if (v[ax] > 0) begin
				p[ax] = clip32(longint'(lo_corner[i][ax]) - h[ax]);
			end else if (v[ax] < 0) begin
				p[ax] = clip32(longint'(hi_corner[i][ax]) + h[ax]);
				if (ax == 1) gnd = 1;
			end
			v[ax] = 0;
		end
	endfunction

	function automatic body_state_t predict_body();
		longint      p [3];
		longint      h [3];
		longint      v [3];
		logic        gnd;
		body_state_t r;
		p = '{position_x, position_y, position_z};
		h = '{half_size_x, half_size_y, half_size_z};
		v = '{velocity_x, velocity_y, velocity_z};
		gnd = 0;
		v[1] = clip32(v[1] - scale_dt(gravity, step_dt));
		p[0] = clip32(p[0] + scale_dt(v[0], step_dt));
		push_out(p, h, v, 0, gnd);
		p[2] = clip32(p[2] + scale_dt(v[2], step_dt));
		push_out(p, h, v, 2, gnd);
		p[1] = clip32(p[1] + scale_dt(v[1], step_dt));
		push_out(p, h, v, 1, gnd);
		for (int a = 0; a < 3; a++) begin
			r.pos[a] = p[a][31:0];
			r.vel[a] = v[a][31:0];
		end
		r.gnd = gnd;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		body_state_t e;
		longint      c [3];
		longint      hs [3];
		if (!arst_n) begin
			expected_bodies.delete();
			stored_boxes = 0;
			step_dt = TimeStepReset;
			fail_count = 0;
			pending = 0;
			steps_seen = 0;
			grounded_seen = 0;
		end else begin
			// Compare a result transaction with the oldest prediction.
			if (result_valid) begin
				if (expected_bodies.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					e = expected_bodies.pop_front();
					if (new_position_x !== e.pos[0]) report_mismatch("pos_x", new_position_x, e.pos[0]);
					if (new_position_y !== e.pos[1]) report_mismatch("pos_y", new_position_y, e.pos[1]);
					if (new_position_z !== e.pos[2]) report_mismatch("pos_z", new_position_z, e.pos[2]);
					if (new_velocity_x !== e.vel[0]) report_mismatch("vel_x", new_velocity_x, e.vel[0]);
					if (new_velocity_y !== e.vel[1]) report_mismatch("vel_y", new_velocity_y, e.vel[1]);
					if (new_velocity_z !== e.vel[2]) report_mismatch("vel_z", new_velocity_z, e.vel[2]);
					if (grounded !== e.gnd) report_mismatch("grounded", grounded, e.gnd);
					steps_seen++;
					if (e.gnd) grounded_seen++;
				end
			end
			// Track the command transaction in the local box table.
			if (start && !busy) begin
				case (op_t'(operation))
					OP_CLEAR: stored_boxes = 0;
					OP_ADD: begin
						if (stored_boxes < MaxBoxes) begin
							c = '{position_x, position_y, position_z};
							hs = '{half_size_x, half_size_y, half_size_z};
							for (int a = 0; a < 3; a++) begin
								lo_corner[stored_boxes][a] = clip32(c[a] - hs[a]);
								hi_corner[stored_boxes][a] = clip32(c[a] + hs[a]);
							end
							stored_boxes++;
						end
					end
					OP_STEP: expected_bodies.push_back(predict_body());
					default: ;
				endcase
			end
			if (time_step_valid && time_step_ready) step_dt = time_step_data;
			pending = expected_bodies.size();
		end
	end

	final begin
		if (expected_bodies.size() != 0)
			$display("%0d predicted steps never returned", expected_bodies.size());
	end
endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// AABB collision step testbench
// Drives box table commands, body steps and time step writes with random
// gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import aabb_pkg::*;

	localparam int StallLimit = 20000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic signed [31:0] position_x, position_y, position_z;
	logic [30:0]        half_size_x, half_size_y, half_size_z;
	logic signed [31:0] velocity_x, velocity_y, velocity_z;
	logic signed [31:0] gravity;
	logic               time_step_valid;
	logic               time_step_ready;
	logic [16:0]        time_step_data;
	logic               result_valid;
	logic signed [31:0] new_position_x, new_position_y, new_position_z;
	logic signed [31:0] new_velocity_x, new_velocity_y, new_velocity_z;
	logic               grounded;
	int                 fail_count, pending, steps_seen, grounded_seen;
	int                 idle_cycles;
	int                 gap_pct;
	int                 boxes_added;

	aabb_gravity_collision_step dut (.*);
	aabb_step_checker chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: cycles with no accepted transaction of any kind.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (time_step_valid && time_step_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// Sends one command transaction after a random gap.
	task automatic send_cmd(input op_t op, input logic [31:0] px, py, pz,
			input logic [30:0] hx, hy, hz, input logic [31:0] vx, vy, vz, g);
		while ($urandom_range(0, 99) < gap_pct) @(negedge clk);
		start <= 1'b1;
		operation <= op;
		{position_x, position_y, position_z} <= {px, py, pz};
		{half_size_x, half_size_y, half_size_z} <= {hx, hy, hz};
		{velocity_x, velocity_y, velocity_z} <= {vx, vy, vz};
		gravity <= g;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 1'b0;
		if (op == OP_ADD && boxes_added < MaxBoxes) boxes_added++;
		if (op == OP_CLEAR) boxes_added = 0;
	endtask

	// Waits for every outstanding step, then lets the block settle.
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_dt(input logic [16:0] v);
		drain();
		time_step_valid <= 1'b1;
		time_step_data <= v;
		do @(posedge clk); while (!time_step_ready);
		@(negedge clk);
		time_step_valid <= 1'b0;
	endtask

	// A box near the origin so that random bodies often hit it.
	task automatic add_near_box();
		send_cmd(OP_ADD, $signed($urandom_range(0, 20 << 16)) - (10 << 16),
			$signed($urandom_range(0, 20 << 16)) - (10 << 16),
			$signed($urandom_range(0, 20 << 16)) - (10 << 16),
			$urandom_range(1, 4 << 16), $urandom_range(1, 4 << 16),
			$urandom_range(1, 4 << 16), 0, 0, 0, 0);
	endtask

	// A body near the boxes with moderate velocity, or a fully random one.
	task automatic step_body();
		if ($urandom_range(0, 9) < 8)
			send_cmd(OP_STEP, $signed($urandom_range(0, 24 << 16)) - (12 << 16),
				$signed($urandom_range(0, 24 << 16)) - (12 << 16),
				$signed($urandom_range(0, 24 << 16)) - (12 << 16),
				$urandom_range(0, 2 << 16), $urandom_range(0, 2 << 16),
				$urandom_range(0, 2 << 16),
				$signed($urandom_range(0, 600 << 16)) - (300 << 16),
				$signed($urandom_range(0, 600 << 16)) - (300 << 16),
				$signed($urandom_range(0, 600 << 16)) - (300 << 16),
				$urandom_range(0, 20 << 16));
		else
			send_cmd(OP_STEP, any_word(), any_word(), any_word(), any_word(),
				any_word(), any_word(), any_word(), any_word(), any_word(), any_word());
	endtask

	initial begin
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_NONE;
		{position_x, position_y, position_z} = '0;
		{half_size_x, half_size_y, half_size_z} = '0;
		{velocity_x, velocity_y, velocity_z} = '0;
		gravity = '0;
		time_step_valid = 1'b0;
		time_step_data = '0;
		idle_cycles = 0;
		gap_pct = 0;
		boxes_added = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty table, field extremes, landing, unused op, full table.
		step_body();
		send_cmd(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1, '1,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_cmd(OP_ADD, 0, 0, 0, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 0);
		send_cmd(OP_STEP, 0, 2 << 16, 0, 1 << 16, 1 << 16, 1 << 16, 0,
			-(60 << 16), 0, 10 << 16);
		send_cmd(OP_STEP, -(2 << 16), 0, 0, 1 << 16, 1 << 16, 1 << 16,
			60 << 16, 0, 0, 0);
		send_cmd(OP_STEP, 0, 0, 2 << 16, 1 << 16, 1 << 16, 1 << 16, 0, 0,
			-(60 << 16), 0);
		send_cmd(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1,
			0, 0, 0, 0);
		send_cmd(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
		send_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < MaxBoxes + 2; i++) add_near_box();
		step_body();
		write_dt(17'h1FFFF);
		step_body();
		write_dt(17'd0);
		step_body();
		write_dt(17'd65536);
		step_body();
		send_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		drain();

		// Random phases with different gaps and time steps.
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 35 : ((phase == 1) ? 79 : 0);
			write_dt(phase == 2 ? 17'd65536 : $urandom_range(1, 8192));
			for (int n = 0; n < 356; n++) begin
				r = $urandom_range(0, 99);
				if (r < 2) send_cmd(OP_CLEAR, any_word(), 0, 0, 0, 0, 0, 0, 0, 0, 0);
				else if (r < 4) send_cmd(OP_NONE, any_word(), 0, 0, 0, 0, 0, 0, 0, 0, 0);
				else if (r < 20 && boxes_added < 12) add_near_box();
				else step_body();
				if (n == 178) drain();
			end
		end
		drain();
		repeat (50) @(negedge clk);

		$display("Covered %0d body steps, %0d of them grounded, over several time steps.",
			steps_seen, grounded_seen);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
